### rtl/rgp_pkg.sv
`default_nettype none
package rgp_pkg;

  localparam int unsigned BinIndexBitsDefault = 10;
  localparam int unsigned HistSizeDefault     = 16;
  localparam int unsigned WordBytesDefault    = 4;

  localparam int unsigned AddrW = 48;
  localparam int unsigned CntW  = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgPredictMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGranuleLog2    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBinLog2        = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRegionThreshold = 2'd3;

  localparam logic [1:0] ModeAligned = 2'd0;
  localparam logic [1:0] ModeExact   = 2'd1;
  localparam logic [1:0] ModeHint    = 2'd2;

  localparam logic [2:0]  GranuleLog2Reset = 3'd6;
  localparam logic [4:0]  BinLog2Reset     = 5'd12;
  localparam logic [15:0] ThresholdReset   = 16'd1;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StTrScan,
    StTrWrite,
    StPrStart,
    StPrThresh,
    StPrScan,
    StPrHint,
    StEmit
  } state_e;

endpackage
`default_nettype wire

### rtl/rgp_ram.sv
`default_nettype none
module rgp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/region_granularity_predictor_unit.sv
`default_nettype none
// Region granularity predictor.
// Input beats arrive on s_axis: tuser is cmd (0 predict, 1 train), tdata holds
// address, access_size, ins_count, used_bitmap and record_words. Predict beats
// produce one or more block beats on m_axis, tlast marking the final block.
// Train beats produce nothing on m_axis.
// The cfg channel writes one of four registers; cfg_ready_o is always high.
// After reset both counter memories are swept to zero, one entry per cycle, over
// (2**BIN_INDEX_BITS)*HIST_SIZE entries; s_axis_tready_o stays low meanwhile.
// One item is handled at a time, s_axis_tready_o is high only when idle.
// Train: scans used_bitmap (record_words capped at 16); each run of set bits is
// a read-modify-write of the count memory and, for runs under HIST_SIZE, the
// histogram, read as the scan ends the run and written in the next state.
// Predict: aligned and exact mode go straight from a start state to the output;
// hint mode adds a count read state and, if the count reaches the threshold, a
// scan of the HIST_SIZE histogram entries and a state to form the block.
// Each block waits in the output register until taken; a stalled receiver
// holds the block and the block accepts no new item until the last is taken.
module region_granularity_predictor_unit #(
  parameter int unsigned BIN_INDEX_BITS = rgp_pkg::BinIndexBitsDefault,
  parameter int unsigned HIST_SIZE      = rgp_pkg::HistSizeDefault,
  parameter int unsigned WORD_BYTES     = rgp_pkg::WordBytesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // address[47:0], access_size[54:48], ins_count[102:55], used_bitmap[118:103],
  // record_words[123:119], zero fill [127:124]
  input  wire logic [127:0] s_axis_tdata_i,
  // cmd[0]
  input  wire logic         s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // block_start[47:0], block_end[95:48], ins_count_out[143:96]
  output logic [143:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [rgp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rgp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW       = rgp_pkg::AddrW;
  localparam int unsigned CW       = rgp_pkg::CntW;
  localparam int unsigned BinCount = 2 ** BIN_INDEX_BITS;
  localparam int unsigned HDepth   = BinCount * HIST_SIZE;
  localparam int unsigned HaW      = $clog2(HDepth);
  localparam int unsigned HbW      = $clog2(HIST_SIZE);

  rgp_pkg::state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic [2:0]  glog_q;
  logic [4:0]  blog_q;
  logic [15:0] thr_q;

  logic [AW-1:0] addr_q, addr_d, ins_q, ins_d;
  logic [6:0]    size_q, size_d;
  logic [15:0]   bm_q, bm_d;
  logic [4:0]    n_q, n_d, idx_q, idx_d, len_q, len_d, run_q, run_d;
  logic          cmd_q, cmd_d;
  logic [AW-1:0] as_q, as_d, ae_q, ae_d;
  logic [HbW-1:0] sidx_q, sidx_d, best_q, best_d;
  logic [CW-1:0] mx_q, mx_d;
  logic [HaW-1:0] clr_q, clr_d;
  logic [AW-1:0] ob_start_q, ob_start_d, ob_end_q, ob_end_d;
  logic          ob_last_q, ob_last_d;

  logic                      h_we, c_we;
  logic [HaW-1:0]            h_waddr, h_raddr;
  logic [BIN_INDEX_BITS-1:0] c_waddr;
  logic [CW-1:0]             h_wdata, c_wdata, h_rdata, c_rdata;

  logic [BIN_INDEX_BITS-1:0] bin;
  logic [HaW-1:0]            hbase;
  logic [2:0]                g;
  logic [AW-1:0]             gb, gmask, end_a, bw, e2, ea;
  logic                      bit_set, in_hs, out_hs, clr_done;
  logic [6:0]                sz_in;
  logic [4:0]                rw_in;

  assign in_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  assign s_axis_tready_o = (state_q == rgp_pkg::StIdle);
  assign m_axis_tvalid_o = (state_q == rgp_pkg::StEmit);
  assign m_axis_tdata_o  = {ins_q, ob_end_q, ob_start_q};
  assign m_axis_tlast_o  = ob_last_q;
  assign cfg_ready_o     = 1'b1;

  assign bin      = BIN_INDEX_BITS'(addr_q >> blog_q);
  assign hbase    = HaW'(32'(bin) * HIST_SIZE);
  assign g        = (glog_q < 3'd2) ? 3'd2 : glog_q;
  assign gb       = AW'(1) << g;
  assign gmask    = ~(gb - AW'(1));
  assign end_a    = addr_q + AW'(size_q) - AW'(1);
  assign bit_set  = (idx_q < n_q) && bm_q[idx_q[3:0]];
  assign clr_done = (32'(clr_q) == HDepth - 1);
  assign bw       = AW'(best_q) * AW'(WORD_BYTES);
  assign e2       = addr_q + bw - AW'(1);
  assign sz_in    = s_axis_tdata_i[54:48];
  assign rw_in    = s_axis_tdata_i[123:119];

  always_comb begin
    if (as_q != ae_q) begin
      ea = addr_q + AW'(size_q) - AW'(WORD_BYTES);
    end else if ((e2 & gmask) != as_q) begin
      ea = as_q + gb - AW'(WORD_BYTES);
    end else begin
      ea = addr_q + bw - AW'(WORD_BYTES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rgp_pkg::ModeAligned;
      glog_q <= rgp_pkg::GranuleLog2Reset;
      blog_q <= rgp_pkg::BinLog2Reset;
      thr_q  <= rgp_pkg::ThresholdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rgp_pkg::CfgPredictMode:     mode_q <= cfg_data_i[1:0];
        rgp_pkg::CfgGranuleLog2:     glog_q <= cfg_data_i[2:0];
        rgp_pkg::CfgBinLog2:         blog_q <= cfg_data_i[4:0];
        rgp_pkg::CfgRegionThreshold: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rgp_pkg::StClear: if (clr_done) state_d = rgp_pkg::StIdle;
      rgp_pkg::StIdle: begin
        if (in_hs) state_d = s_axis_tuser_i ? rgp_pkg::StTrScan : rgp_pkg::StPrStart;
      end
      rgp_pkg::StTrScan: begin
        if (!bit_set) begin
          if (len_q != 5'd0) state_d = rgp_pkg::StTrWrite;
          else if (idx_q == n_q) state_d = rgp_pkg::StIdle;
        end
      end
      rgp_pkg::StTrWrite: state_d = (idx_q > n_q) ? rgp_pkg::StIdle : rgp_pkg::StTrScan;
      rgp_pkg::StPrStart: state_d = (mode_q == rgp_pkg::ModeHint) ? rgp_pkg::StPrThresh
                                                                  : rgp_pkg::StEmit;
      rgp_pkg::StPrThresh: state_d = (c_rdata < thr_q) ? rgp_pkg::StEmit : rgp_pkg::StPrScan;
      rgp_pkg::StPrScan: if (32'(sidx_q) == HIST_SIZE - 1) state_d = rgp_pkg::StPrHint;
      rgp_pkg::StPrHint: state_d = rgp_pkg::StEmit;
      rgp_pkg::StEmit: if (out_hs && ob_last_q) state_d = rgp_pkg::StIdle;
      default: state_d = rgp_pkg::StClear;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    addr_d = addr_q; ins_d = ins_q; size_d = size_q; bm_d = bm_q; n_d = n_q;
    cmd_d = cmd_q; idx_d = idx_q; len_d = len_q; run_d = run_q;
    as_d = as_q; ae_d = ae_q; sidx_d = sidx_q; best_d = best_q; mx_d = mx_q;
    clr_d = clr_q; ob_start_d = ob_start_q; ob_end_d = ob_end_q; ob_last_d = ob_last_q;
    h_we = 1'b0; c_we = 1'b0;
    h_waddr = hbase + HaW'(run_q);
    c_waddr = bin;
    h_wdata = h_rdata + CW'(h_rdata != rgp_pkg::CntMax);
    c_wdata = c_rdata + CW'(c_rdata != rgp_pkg::CntMax);
    h_raddr = hbase + HaW'(len_q);
    case (state_q)
      rgp_pkg::StClear: begin
        h_we = 1'b1; h_waddr = clr_q; h_wdata = '0;
        c_we = (32'(clr_q) < BinCount); c_waddr = clr_q[BIN_INDEX_BITS-1:0]; c_wdata = '0;
        clr_d = clr_q + HaW'(1);
      end
      rgp_pkg::StIdle: begin
        addr_d = s_axis_tdata_i[47:0];
        ins_d  = s_axis_tdata_i[102:55];
        bm_d   = s_axis_tdata_i[118:103];
        cmd_d  = s_axis_tuser_i;
        size_d = (sz_in == 7'd0) ? 7'd1 : ((sz_in > 7'd64) ? 7'd64 : sz_in);
        n_d    = (rw_in > 5'd16) ? 5'd16 : rw_in;
        idx_d  = 5'd0;
        len_d  = 5'd0;
      end
      rgp_pkg::StTrScan: begin
        // read both counters for the run that ends here
        if (bit_set) begin
          len_d = len_q + 5'd1;
          idx_d = idx_q + 5'd1;
        end else begin
          run_d = len_q;
          len_d = 5'd0;
          if (len_q != 5'd0 || idx_q != n_q) idx_d = idx_q + 5'd1;
        end
      end
      rgp_pkg::StTrWrite: begin
        h_we = (32'(run_q) < HIST_SIZE);
        c_we = 1'b1;
      end
      rgp_pkg::StPrStart: begin
        as_d = addr_q & gmask;
        ae_d = end_a & gmask;
        ob_start_d = end_a & gmask;
        ob_end_d   = (end_a & gmask) + gb - AW'(WORD_BYTES);
        ob_last_d  = ((addr_q & gmask) == (end_a & gmask));
        if (mode_q != rgp_pkg::ModeAligned && mode_q != rgp_pkg::ModeHint) begin
          ob_start_d = addr_q;
          ob_end_d   = addr_q + AW'(size_q) - AW'(WORD_BYTES);
          ob_last_d  = 1'b1;
        end
        h_raddr = hbase;
      end
      rgp_pkg::StPrThresh: begin
        h_raddr = hbase;
        sidx_d  = '0;
        best_d  = HbW'(1);
        mx_d    = '0;
      end
      rgp_pkg::StPrScan: begin
        if (h_rdata > mx_q) begin
          mx_d   = h_rdata;
          best_d = sidx_q;
        end
        sidx_d  = sidx_q + HbW'(1);
        h_raddr = hbase + HaW'(sidx_q) + HaW'(1);
      end
      rgp_pkg::StPrHint: begin
        if (best_q == '0) best_d = HbW'(1);
        ob_start_d = addr_q;
        ob_end_d   = ea;
        ob_last_d  = 1'b1;
      end
      rgp_pkg::StEmit: begin
        // step down one granule per taken beat
        if (out_hs && !ob_last_q) begin
          ob_start_d = ob_start_q - gb;
          ob_end_d   = ob_start_q - AW'(WORD_BYTES);
          ob_last_d  = ((ob_start_q - gb) == as_q);
        end
      end
      default: ;
    endcase
  end

  // a zero best index is already mapped to one before the end address uses it
  logic [HbW-1:0] best_fix;
  assign best_fix = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgp_pkg::StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d; ins_q <= ins_d; size_q <= size_d; bm_q <= bm_d; n_q <= n_d;
    cmd_q <= cmd_d; idx_q <= idx_d; len_q <= len_d; run_q <= run_d;
    as_q <= as_d; ae_q <= ae_d; sidx_q <= sidx_d; mx_q <= mx_d;
    best_q <= (state_q == rgp_pkg::StPrScan && 32'(sidx_q) == HIST_SIZE - 1 &&
               !(h_rdata > mx_q) && best_fix == '0) ? HbW'(1) : best_d;
    ob_start_q <= ob_start_d; ob_end_q <= ob_end_d; ob_last_q <= ob_last_d;
  end

  rgp_ram #(.Width(CW), .Depth(HDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  rgp_ram #(.Width(CW), .Depth(BinCount)) u_count (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (bin),
    .rdata_o (c_rdata)
  );

  a_no_accept_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o) else $error("input taken while block pending");

  a_burst_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("block burst broken before last");

  a_train_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgp_pkg::StTrScan || state_q == rgp_pkg::StTrWrite) |-> cmd_q)
    else $error("train walk on a predict item");

  a_scan_hint_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgp_pkg::StPrScan) |-> (mode_q == rgp_pkg::ModeHint))
    else $error("histogram scan outside hint mode");

endmodule
`default_nettype wire
